// ===== design/nbe_pkg.sv =====
// shared types, constants and functions of the n-tuple board evaluator
// no dependencies; imported by every module of the block except nbe_ram
package nbe_pkg;

    // sizing of the weight store and of the fields
    localparam int TILE_VALUES   = 16;
    localparam int PATTERN_COUNT = 8;
    localparam int WEIGHT_BITS   = 32;
    localparam int TABLE_DEPTH   = 65536;
    localparam int IDX_BITS      = 16;
    localparam int CMD_BITS      = 3;
    localparam int BOARD_BITS    = 64;
    localparam int SEL_BITS      = 3;
    localparam int WIN_BITS      = 32;
    localparam int OUT_BITS      = 35;

    // stream packing: cmd travels in tuser, the other fields in tdata
    localparam int BOARD_LSB     = 0;
    localparam int SEL_LSB       = BOARD_LSB + BOARD_BITS;
    localparam int RAW_LSB       = SEL_LSB + SEL_BITS;
    localparam int WIN_LSB       = RAW_LSB + IDX_BITS;
    localparam int S_USED_BITS   = WIN_LSB + WIN_BITS;
    localparam int S_TDATA_BITS  = ((S_USED_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

    // internal widths
    localparam int WEXT_BITS     = (WEIGHT_BITS > WIN_BITS) ? WEIGHT_BITS : WIN_BITS;
    localparam int SUM_BITS      = (WEIGHT_BITS + 3 > OUT_BITS) ? WEIGHT_BITS + 3 : OUT_BITS;
    localparam int CNT_BITS      = $clog2(PATTERN_COUNT + 1);
    localparam int QUEUE_DEPTH   = 2;

    // powers of the tile count, taken modulo the table depth
    localparam logic [IDX_BITS-1:0] TILE_P1 = IDX_BITS'(TILE_VALUES);
    localparam logic [IDX_BITS-1:0] TILE_P2 = IDX_BITS'(TILE_VALUES * TILE_VALUES);
    localparam logic [IDX_BITS-1:0] TILE_P3 =
        IDX_BITS'(TILE_VALUES * TILE_VALUES * TILE_VALUES);

    // saturation limits
    localparam logic signed [WEXT_BITS-1:0] W_HI =
        WEXT_BITS'({1'b0, {(WEIGHT_BITS - 1){1'b1}}});
    localparam logic signed [WEXT_BITS-1:0] W_LO = ~W_HI;
    localparam logic signed [SUM_BITS-1:0] O_HI =
        SUM_BITS'({1'b0, {(OUT_BITS - 1){1'b1}}});
    localparam logic signed [SUM_BITS-1:0] O_LO = ~O_HI;

    // command codes on the input stream
    localparam logic [CMD_BITS-1:0] CMD_EVAL      = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ_PAT  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_WRITE_PAT = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_WRITE_RAW = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_READ_RAW  = 3'd4;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_EVAL,
        OP_READ,
        OP_WRITE,
        OP_ZERO
    } nbe_op_t;

    typedef struct packed {
        nbe_op_t                        op;
        logic [BOARD_BITS-1:0]          board;
        logic [IDX_BITS-1:0]            addr;
        logic signed [WEIGHT_BITS-1:0]  weight;
    } nbe_entry_t;

    // cell numbers of each pattern, first cell in the lowest nibble
    function automatic logic [15:0] pattern_cells(input logic [SEL_BITS-1:0] p);
        logic [15:0] cells;
        case (p)
            3'd0:    cells = {4'd7,  4'd6,  4'd5,  4'd4};
            3'd1:    cells = {4'd1,  4'd5,  4'd9,  4'd13};
            3'd2:    cells = {4'd14, 4'd10, 4'd6,  4'd2};
            3'd3:    cells = {4'd8,  4'd9,  4'd10, 4'd11};
            3'd4:    cells = {4'd4,  4'd5,  4'd6,  4'd7};
            3'd5:    cells = {4'd13, 4'd9,  4'd5,  4'd1};
            3'd6:    cells = {4'd11, 4'd10, 4'd9,  4'd8};
            3'd7:    cells = {4'd2,  4'd6,  4'd10, 4'd14};
            default: cells = '0;
        endcase
        return cells;
    endfunction

    function automatic logic [3:0] cell_of(input logic [BOARD_BITS-1:0] board,
                                           input logic [3:0] k);
        return board[{k, 2'b00} +: 4];
    endfunction

    // table index c0 + c1*T + c2*T^2 + c3*T^3, wrapped to the table depth
    function automatic logic [IDX_BITS-1:0] tuple_index(input logic [3:0] c0,
                                                        input logic [3:0] c1,
                                                        input logic [3:0] c2,
                                                        input logic [3:0] c3);
        return IDX_BITS'(c0) + IDX_BITS'(c1) * TILE_P1 + IDX_BITS'(c2) * TILE_P2
             + IDX_BITS'(c3) * TILE_P3;
    endfunction

    function automatic logic [IDX_BITS-1:0] pattern_index(
            input logic [BOARD_BITS-1:0] board, input logic [SEL_BITS-1:0] p);
        logic [15:0] cells;
        cells = pattern_cells(p);
        return tuple_index(cell_of(board, cells[3:0]), cell_of(board, cells[7:4]),
                           cell_of(board, cells[11:8]), cell_of(board, cells[15:12]));
    endfunction

    // clamp an incoming weight to the stored width
    function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
            input logic signed [WIN_BITS-1:0] w);
        logic signed [WEXT_BITS-1:0] v;
        v = WEXT_BITS'(w);
        if (v > W_HI) begin
            v = W_HI;
        end else if (v < W_LO) begin
            v = W_LO;
        end
        return WEIGHT_BITS'(v);
    endfunction

    // clamp a sum or a read weight to the result width
    function automatic logic signed [OUT_BITS-1:0] sat_out(
            input logic signed [SUM_BITS-1:0] s);
        logic signed [SUM_BITS-1:0] v;
        v = s;
        if (v > O_HI) begin
            v = O_HI;
        end else if (v < O_LO) begin
            v = O_LO;
        end
        return OUT_BITS'(v);
    endfunction

endpackage

// ===== design/nbe_ram.sv =====
// generic single-port ram with registered read
// no dependencies; holds the weight table
module nbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/nbe_front.sv =====
// front end: accepts items, decodes the command, forms the table index
// depends on nbe_pkg
module nbe_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nbe_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic [nbe_pkg::CMD_BITS-1:0]      s_tuser,
    input  logic                              q_full,
    input  logic                              clearing,
    output logic                              push,
    output nbe_pkg::nbe_entry_t               push_entry
);
    import nbe_pkg::*;

    logic [BOARD_BITS-1:0]  board;
    logic [SEL_BITS-1:0]    sel;
    logic [IDX_BITS-1:0]    raw;
    logic [WIN_BITS-1:0]    win;
    logic                   sel_ok;
    logic [IDX_BITS-1:0]    pat_idx;
    logic [IDX_BITS-1:0]    raw_idx;

    // field unpacking
    assign board = s_tdata[BOARD_LSB +: BOARD_BITS];
    assign sel   = s_tdata[SEL_LSB +: SEL_BITS];
    assign raw   = s_tdata[RAW_LSB +: IDX_BITS];
    assign win   = s_tdata[WIN_LSB +: WIN_BITS];

    // handshake: hold off while the store is being cleared or the queue is full
    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready;

    assign sel_ok  = (32'(sel) < PATTERN_COUNT);
    assign pat_idx = pattern_index(board, sel);
    assign raw_idx = tuple_index(raw[3:0], raw[7:4], raw[11:8], raw[15:12]);

    // classify the item
    always_comb begin
        push_entry.board  = board;
        push_entry.weight = sat_weight(signed'(win));
        push_entry.addr   = pat_idx;
        push_entry.op     = OP_ZERO;
        unique case (s_tuser)
            CMD_EVAL: begin
                push_entry.op = OP_EVAL;
            end
            CMD_READ_PAT: begin
                push_entry.op = sel_ok ? OP_READ : OP_ZERO;
            end
            CMD_WRITE_PAT: begin
                push_entry.op = sel_ok ? OP_WRITE : OP_ZERO;
            end
            CMD_WRITE_RAW: begin
                push_entry.op   = OP_WRITE;
                push_entry.addr = raw_idx;
            end
            CMD_READ_RAW: begin
                push_entry.op   = OP_READ;
                push_entry.addr = raw_idx;
            end
            default: begin
                push_entry.op = OP_ZERO;
            end
        endcase
    end

endmodule

// ===== design/nbe_queue.sv =====
// short register queue between the front and the back
// depends on nbe_pkg
module nbe_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  nbe_pkg::nbe_entry_t  push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output nbe_pkg::nbe_entry_t  pop_entry
);
    import nbe_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    nbe_entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/nbe_back.sv =====
// back end: clears the weight store, runs reads, writes and board sums,
// holds the result register; depends on nbe_pkg and nbe_ram
module nbe_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  nbe_pkg::nbe_entry_t                q_entry,
    output logic                               pop,
    output logic                               clearing,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic signed [nbe_pkg::OUT_BITS-1:0] result_value
);
    import nbe_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_BITS-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic signed [SUM_BITS-1:0]    acc_reg, acc_next;
    logic [BOARD_BITS-1:0]         board_reg, board_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0]    out_data_reg, out_data_next;

    logic                          ram_we;
    logic [IDX_BITS-1:0]           ram_addr;
    logic [WEIGHT_BITS-1:0]        ram_wdata;
    logic signed [WEIGHT_BITS-1:0] rd_data;
    logic signed [SUM_BITS-1:0]    rd_ext;
    logic signed [SUM_BITS-1:0]    acc_sum;
    logic                          out_free;

    nbe_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_data)
    );

    assign rd_ext   = SUM_BITS'(rd_data);
    assign acc_sum  = acc_reg + rd_ext;
    assign out_free = !out_valid_reg || m_tready;

    assign clearing     = (state_reg == ST_CLEAR);
    assign m_tvalid     = out_valid_reg;
    assign result_value = out_data_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        board_next     = board_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = q_entry.addr;
        ram_wdata      = q_entry.weight;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    pop = 1'b1;
                    unique case (q_entry.op)
                        OP_WRITE: begin
                            ram_we         = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                        OP_READ: begin
                            state_next = ST_READ;
                        end
                        OP_EVAL: begin
                            board_next = q_entry.board;
                            cnt_next   = '0;
                            acc_next   = '0;
                            state_next = ST_EVAL;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_valid_next = 1'b1;
                out_data_next  = sat_out(rd_ext);
                state_next     = ST_IDLE;
            end
            ST_EVAL: begin
                // one pattern read issued per cycle, its weight added in the next cycle
                ram_addr = pattern_index(board_reg, SEL_BITS'(cnt_reg));
                if (cnt_reg != '0) begin
                    acc_next = acc_sum;
                end
                if (cnt_reg == CNT_BITS'(PATTERN_COUNT)) begin
                    out_valid_next = 1'b1;
                    out_data_next  = sat_out(acc_sum);
                    state_next     = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        acc_reg      <= acc_next;
        board_reg    <= board_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== design/ntuple_board_evaluator_top.sv =====
// top level of the n-tuple board evaluator
// depends on nbe_pkg, nbe_front, nbe_queue and nbe_back
//
// After reset the block clears its 65536-entry weight table one entry a cycle,
// so s_tready stays low until the pass is done. Items are then taken into
// a two-entry queue and executed one at a time on the single-ported weight
// memory: a board evaluation has a start step, then one memory read per
// pattern, PATTERN_COUNT reads, and a last step to finish the sum; a pattern
// or raw read waits on the registered read data; writes and unused commands
// are answered as they are popped. Every item gives exactly one result, which
// waits in the output register while later items are queued. Weights are
// signed Q16.16; results are signed Q19.16, clamped, and zero for writes.
module ntuple_board_evaluator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // board [63:0], pattern_select [66:64], raw_entry [82:67],
    // weight_in [114:83], zero fill [119:115]
    input  logic [nbe_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // cmd [2:0]
    input  logic [nbe_pkg::CMD_BITS-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_value [34:0], zero fill [39:35]
    output logic [nbe_pkg::M_TDATA_BITS-1:0]  m_tdata
);
    import nbe_pkg::*;

    logic                       push;
    nbe_entry_t                 push_entry;
    logic                       q_full;
    logic                       pop;
    logic                       q_valid;
    nbe_entry_t                 q_entry;
    logic                       clearing;
    logic signed [OUT_BITS-1:0] result_value;

    nbe_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_entry (push_entry)
    );

    nbe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    nbe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .pop          (pop),
        .clearing     (clearing),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result_value (result_value)
    );

    // result packed into whole bytes
    assign m_tdata = M_TDATA_BITS'(unsigned'(result_value));

endmodule

// ===== design/nbe_checker.sv =====
// port-level checks of the n-tuple board evaluator, bound to the top level
// depends on nbe_pkg and ntuple_board_evaluator_top
module nbe_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [nbe_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input logic [nbe_pkg::CMD_BITS-1:0]      s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [nbe_pkg::M_TDATA_BITS-1:0]  m_tdata
);
    import nbe_pkg::*;

    // no result straight after reset
    a_no_result_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result offered right after reset");

    // the clearing pass starts at reset and holds off input
    a_clear_blocks_input: assert property (
        @(posedge aclk) !aresetn |=> !s_tready
    ) else $error("input taken before the weight store was cleared");

    // a stalled result holds
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
    ) else $error("result changed while stalled");

    // fill bits above the result stay zero
    a_result_fill_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_BITS-1:OUT_BITS] == '0)
    ) else $error("fill bits of the result not zero");

endmodule

bind ntuple_board_evaluator_top nbe_checker u_nbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
